// ----- rtl/bgpc_pkg.sv -----
// Package: widths, pipeline depth and helper types of the box ground contact block.
`default_nettype none

package bgpc_pkg;

  localparam int IN_W        = 256;
  localparam int OUT_W       = 96;
  localparam int POS_W       = 32;
  localparam int QUAT_W      = 16;
  localparam int H_W         = 31;
  localparam int QP_W        = 32;
  localparam int RAW_W       = 35;
  localparam int M_W         = 24;
  localparam int P_W         = 56;
  localparam int ACC_W       = 58;
  localparam int WC_W        = 44;
  localparam int PEN_W       = 46;
  localparam int SUM_W       = 48;
  localparam int NUM_W       = SUM_W + 2;
  localparam int CNT_W       = 4;
  localparam int REM_W       = 5;
  localparam int DIV_STAGES  = 7;
  localparam int DIV_STEPS   = 8;
  localparam int DIV_W       = DIV_STAGES * DIV_STEPS;
  localparam int PRE_STAGES  = 8;
  localparam int NSTAGE      = PRE_STAGES + DIV_STAGES + 1;
  localparam int MAT_SHIFT   = 12;
  localparam int POS_SHIFT   = 16;
  localparam int NPROD       = 9;
  localparam int NCORNER     = 8;

  // quaternion product slots
  localparam int PXX = 0;
  localparam int PYY = 1;
  localparam int PZZ = 2;
  localparam int PXY = 3;
  localparam int PWZ = 4;
  localparam int PXZ = 5;
  localparam int PWY = 6;
  localparam int PYZ = 7;
  localparam int PWX = 8;

  typedef struct packed {
    logic [DIV_W-1:0] a;
    logic [REM_W-1:0] r;
  } div_t;

  // advance the restoring division by DIV_STEPS quotient bits
  function automatic div_t div_steps(div_t s, logic [REM_W-1:0] d);
    div_t        o;
    logic [REM_W:0] t;
    o = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t   = {o.r, o.a[DIV_W-1]};
      o.a = {o.a[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t      = t - {1'b0, d};
        o.a[0] = 1'b1;
      end
      o.r = t[REM_W-1:0];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/box_ground_plane_contact.sv -----
// Top level: oriented box against ground plane contact test, pipelined.
//
// Input stream s_axis carries one box per transaction: center, unit
// quaternion and half extents. Output stream m_axis carries one contact
// result per box, in order: hit flag, deepest penetration and the mean x
// and z of the corners below ground (all zero when nothing penetrates).
// cfg_we_i/cfg_wdata_i write the signed Q16.16 ground height; write it
// only while no box is in flight.
// The pipeline has 16 register stages from input transaction to output
// valid. Throughput is one box per cycle while m_axis is not stalled:
// matrix build, nine corner products, corner sums, ground compare and
// reduction, then two radix-2 dividers for the means, eight quotient bits
// per stage over seven stages.
// Each stage holds a valid bit; a stage advances whenever it is empty or
// the stage after it advances, so bubbles collapse and a stall of the
// receiver holds every full stage without loss or repetition.
// Reset clears all valid bits and the ground height to zero.
`default_nettype none

module box_ground_plane_contact
  import bgpc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [POS_W-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // center_x, center_y, center_z, quat_w, quat_x, quat_y, quat_z,
  // half_x, half_y, half_z, zero fill
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // hit, penetration, contact_x, contact_z
  output logic [OUT_W-1:0]      m_axis_tdata
);

  logic signed [POS_W-1:0] g_q;
  logic [NSTAGE-1:0]       v_q;
  logic [NSTAGE-1:0]       rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q <= '0;
    end else if (cfg_we_i) begin
      g_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    rdy[NSTAGE-1] = !v_q[NSTAGE-1] || m_axis_tready;
    for (int k = NSTAGE-2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[NSTAGE-1];

  // input unpack
  logic signed [POS_W-1:0]  in_c [3];
  logic signed [QUAT_W-1:0] qw, qx, qy, qz;
  logic [H_W-1:0]           in_h [3];

  assign in_c[0] = s_axis_tdata[31:0];
  assign in_c[1] = s_axis_tdata[63:32];
  assign in_c[2] = s_axis_tdata[95:64];
  assign qw      = s_axis_tdata[111:96];
  assign qx      = s_axis_tdata[127:112];
  assign qy      = s_axis_tdata[143:128];
  assign qz      = s_axis_tdata[159:144];
  assign in_h[0] = s_axis_tdata[190:160];
  assign in_h[1] = s_axis_tdata[221:191];
  assign in_h[2] = s_axis_tdata[252:222];

  // stage 0: quaternion products
  logic signed [QP_W-1:0]  qp_q [NPROD];
  logic signed [POS_W-1:0] c0_q [3];
  logic [H_W-1:0]          h0_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      qp_q[PXX] <= qx * qx;
      qp_q[PYY] <= qy * qy;
      qp_q[PZZ] <= qz * qz;
      qp_q[PXY] <= qx * qy;
      qp_q[PWZ] <= qw * qz;
      qp_q[PXZ] <= qx * qz;
      qp_q[PWY] <= qw * qy;
      qp_q[PYZ] <= qy * qz;
      qp_q[PWX] <= qw * qx;
      c0_q      <= in_c;
      h0_q      <= in_h;
    end
  end

  // stage 1: rotation matrix, rounded to Q.16
  localparam logic signed [RAW_W-1:0] ONE_Q = RAW_W'(1) <<< (2 * (QUAT_W - 2));
  localparam logic signed [RAW_W-1:0] RND_M = RAW_W'(1) <<< (MAT_SHIFT - 1);

  logic signed [RAW_W-1:0] raw [3][3];
  logic signed [M_W-1:0]   m1_q [3][3];
  logic signed [POS_W-1:0] c1_q [3];
  logic [H_W-1:0]          h1_q [3];

  always_comb begin
    raw[0][0] = ONE_Q - ((RAW_W'(qp_q[PYY]) + RAW_W'(qp_q[PZZ])) <<< 1);
    raw[0][1] = (RAW_W'(qp_q[PXY]) - RAW_W'(qp_q[PWZ])) <<< 1;
    raw[0][2] = (RAW_W'(qp_q[PXZ]) + RAW_W'(qp_q[PWY])) <<< 1;
    raw[1][0] = (RAW_W'(qp_q[PXY]) + RAW_W'(qp_q[PWZ])) <<< 1;
    raw[1][1] = ONE_Q - ((RAW_W'(qp_q[PXX]) + RAW_W'(qp_q[PZZ])) <<< 1);
    raw[1][2] = (RAW_W'(qp_q[PYZ]) - RAW_W'(qp_q[PWX])) <<< 1;
    raw[2][0] = (RAW_W'(qp_q[PXZ]) - RAW_W'(qp_q[PWY])) <<< 1;
    raw[2][1] = (RAW_W'(qp_q[PYZ]) + RAW_W'(qp_q[PWX])) <<< 1;
    raw[2][2] = ONE_Q - ((RAW_W'(qp_q[PXX]) + RAW_W'(qp_q[PYY])) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m1_q[i][j] <= M_W'((raw[i][j] + RND_M) >>> MAT_SHIFT);
        end
      end
      c1_q <= c0_q;
      h1_q <= h0_q;
    end
  end

  // stage 2: matrix entry times half extent
  logic signed [P_W-1:0]   p2_q [3][3];
  logic signed [POS_W-1:0] c2_q [3];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          p2_q[i][k] <= m1_q[i][k] * $signed({1'b0, h1_q[k]});
        end
      end
      c2_q <= c1_q;
    end
  end

  // stage 3: signed sums per corner
  logic signed [ACC_W-1:0] acc3_q [NCORNER][3];
  logic signed [POS_W-1:0] c3_q [3];
  logic signed [ACC_W-1:0] acc [NCORNER][3];

  always_comb begin
    for (int n = 0; n < NCORNER; n++) begin
      for (int i = 0; i < 3; i++) begin
        acc[n][i] = '0;
        for (int k = 0; k < 3; k++) begin
          if (n[2-k]) begin
            acc[n][i] = acc[n][i] + ACC_W'(p2_q[i][k]);
          end else begin
            acc[n][i] = acc[n][i] - ACC_W'(p2_q[i][k]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      acc3_q <= acc;
      c3_q   <= c2_q;
    end
  end

  // stage 4: round to position format, add center
  localparam logic signed [ACC_W-1:0] RND_P = ACC_W'(1) <<< (POS_SHIFT - 1);

  logic signed [WC_W-1:0] wc4_q [NCORNER][3];

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int n = 0; n < NCORNER; n++) begin
        for (int i = 0; i < 3; i++) begin
          wc4_q[n][i] <= WC_W'(c3_q[i]) + WC_W'((acc3_q[n][i] + RND_P) >>> POS_SHIFT);
        end
      end
    end
  end

  // stage 5: ground compare, pairwise reduction
  logic [NCORNER-1:0]      below;
  logic [PEN_W-1:0]        pen [NCORNER];
  logic signed [WC_W-1:0]  mx [NCORNER];
  logic signed [WC_W-1:0]  mz [NCORNER];
  logic [PEN_W-1:0]        pen5_q [4];
  logic signed [SUM_W-1:0] sx5_q [4];
  logic signed [SUM_W-1:0] sz5_q [4];
  logic [CNT_W-1:0]        cnt5_q;

  always_comb begin
    for (int n = 0; n < NCORNER; n++) begin
      below[n] = wc4_q[n][1] < WC_W'(g_q);
      pen[n]   = below[n] ? PEN_W'(PEN_W'(g_q) - PEN_W'(wc4_q[n][1])) : '0;
      mx[n]    = below[n] ? wc4_q[n][0] : '0;
      mz[n]    = below[n] ? wc4_q[n][2] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      for (int j = 0; j < 4; j++) begin
        pen5_q[j] <= (pen[2*j] > pen[2*j+1]) ? pen[2*j] : pen[2*j+1];
        sx5_q[j]  <= SUM_W'(mx[2*j]) + SUM_W'(mx[2*j+1]);
        sz5_q[j]  <= SUM_W'(mz[2*j]) + SUM_W'(mz[2*j+1]);
      end
      cnt5_q <= CNT_W'($countones(below));
    end
  end

  // stage 6: finish reduction
  logic [PEN_W-1:0]        pen6_q;
  logic signed [SUM_W-1:0] sx6_q, sz6_q;
  logic [CNT_W-1:0]        cnt6_q;
  logic [PEN_W-1:0]        pa, pb;

  assign pa = (pen5_q[0] > pen5_q[1]) ? pen5_q[0] : pen5_q[1];
  assign pb = (pen5_q[2] > pen5_q[3]) ? pen5_q[2] : pen5_q[3];

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      pen6_q <= (pa > pb) ? pa : pb;
      sx6_q  <= sx5_q[0] + sx5_q[1] + sx5_q[2] + sx5_q[3];
      sz6_q  <= sz5_q[0] + sz5_q[1] + sz5_q[2] + sz5_q[3];
      cnt6_q <= cnt5_q;
    end
  end

  // stage 7: saturate depth, set up magnitude division
  logic                    hit7_q;
  logic [H_W-1:0]          pen7_q;
  logic [DIV_W-1:0]        a7_q [2];
  logic                    neg7_q [2];
  logic [REM_W-1:0]        d7;
  logic [REM_W-1:0]        d7_q;
  logic signed [NUM_W-1:0] num [2];
  logic signed [NUM_W-1:0] mag [2];

  assign d7 = (cnt6_q == '0) ? REM_W'(2) : {cnt6_q, 1'b0};

  always_comb begin
    num[0] = (NUM_W'(sx6_q) <<< 1) + NUM_W'($signed({1'b0, cnt6_q}));
    num[1] = (NUM_W'(sz6_q) <<< 1) + NUM_W'($signed({1'b0, cnt6_q}));
    for (int l = 0; l < 2; l++) begin
      mag[l] = num[l][NUM_W-1] ?
               (NUM_W'(-num[l]) + NUM_W'($signed({1'b0, d7})) - NUM_W'(1)) : num[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      hit7_q <= cnt6_q != '0;
      pen7_q <= (|pen6_q[PEN_W-1:H_W]) ? '1 : pen6_q[H_W-1:0];
      for (int l = 0; l < 2; l++) begin
        a7_q[l]   <= DIV_W'($unsigned(mag[l]));
        neg7_q[l] <= num[l][NUM_W-1];
      end
      d7_q <= d7;
    end
  end

  // stages 8 to 14: mean dividers
  div_t             dv_q   [DIV_STAGES][2];
  logic             dneg_q [DIV_STAGES][2];
  logic [REM_W-1:0] dd_q   [DIV_STAGES];
  logic             dhit_q [DIV_STAGES];
  logic [H_W-1:0]   dpen_q [DIV_STAGES];

  div_t             dv_in   [DIV_STAGES][2];
  logic             dneg_in [DIV_STAGES][2];
  logic [REM_W-1:0] dd_in   [DIV_STAGES];
  logic             dhit_in [DIV_STAGES];
  logic [H_W-1:0]   dpen_in [DIV_STAGES];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dv_in[0][l].a   = a7_q[l];
      dv_in[0][l].r   = '0;
      dneg_in[0][l]   = neg7_q[l];
    end
    dd_in[0]   = d7_q;
    dhit_in[0] = hit7_q;
    dpen_in[0] = pen7_q;
    for (int j = 1; j < DIV_STAGES; j++) begin
      dv_in[j]   = dv_q[j-1];
      dneg_in[j] = dneg_q[j-1];
      dd_in[j]   = dd_q[j-1];
      dhit_in[j] = dhit_q[j-1];
      dpen_in[j] = dpen_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (rdy[PRE_STAGES+j]) begin
        for (int l = 0; l < 2; l++) begin
          dv_q[j][l]   <= div_steps(dv_in[j][l], dd_in[j]);
          dneg_q[j][l] <= dneg_in[j][l];
        end
        dd_q[j]   <= dd_in[j];
        dhit_q[j] <= dhit_in[j];
        dpen_q[j] <= dpen_in[j];
      end
    end
  end

  // stage 15: sign, saturate, output register
  localparam logic signed [DIV_W:0] SMAX = (DIV_W+1)'(32'sh7fffffff);
  localparam logic signed [DIV_W:0] SMIN = (DIV_W+1)'(-33'sh80000000);

  logic signed [DIV_W:0]   sq [2];
  logic signed [POS_W-1:0] mean [2];
  logic                    ohit_q;
  logic [H_W-1:0]          open_q;
  logic signed [POS_W-1:0] omean_q [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sq[l] = dneg_q[DIV_STAGES-1][l] ? -$signed({1'b0, dv_q[DIV_STAGES-1][l].a})
                                       :  $signed({1'b0, dv_q[DIV_STAGES-1][l].a});
      if (sq[l] > SMAX) begin
        mean[l] = SMAX[POS_W-1:0];
      end else if (sq[l] < SMIN) begin
        mean[l] = SMIN[POS_W-1:0];
      end else begin
        mean[l] = sq[l][POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NSTAGE-1]) begin
      ohit_q <= dhit_q[DIV_STAGES-1];
      open_q <= dhit_q[DIV_STAGES-1] ? dpen_q[DIV_STAGES-1] : '0;
      for (int l = 0; l < 2; l++) begin
        omean_q[l] <= dhit_q[DIV_STAGES-1] ? mean[l] : '0;
      end
    end
  end

  assign m_axis_tdata = {omean_q[1], omean_q[0], open_q, ohit_q};

endmodule

`default_nettype wire

// ----- rtl/bgpc_chk.sv -----
// Checker: port-level properties of the box ground contact block, with bind.
`default_nettype none

module bgpc_chk
  import bgpc_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  // hold a stalled transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_W-1:1] == '0)
    else $error("miss result carries nonzero fields");

  a_hit_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[31:1] != '0)
    else $error("hit result with zero penetration");

endmodule

bind box_ground_plane_contact bgpc_chk u_bgpc_chk (.*);

`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for box_ground_plane_contact: directed table plus random boxes checked by a predictor.
`timescale 1ns / 1ps

module tb_top
  import bgpc_pkg::*;
;

  typedef struct packed {
    logic signed [31:0] cx, cy, cz;
    logic signed [15:0] qw, qx, qy, qz;
    logic [30:0] hx, hy, hz;
  } box_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] pen;
    logic signed [31:0] cx, cz;
  } contact_t;

  typedef struct packed {
    box_t     b;
    logic     typed;
    contact_t r;
  } row_t;

  localparam int NDIR = 12;
  localparam int NRND = 1300;
  localparam int WDOG = 3000;
  localparam int TAIL = 24;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [POS_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  box_ground_plane_contact dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  contact_t          pending_contacts[$];
  logic signed [31:0] ground_q = '0;
  int                mismatches = 0;
  int                n_boxes = 0;
  int                n_contacts = 0;
  int                n_hits = 0;
  int                idle_s = 0;
  int                idle_r = 0;
  int                quiet = 0;
  row_t              dir_tab[NDIR];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic contact_t contact_of(box_t b, logic signed [31:0] gnd);
    contact_t r;
    longint w, x, y, z, one, maxpen, sumx, sumz, acc, pen;
    longint c[3], h[3], loc[3], wc[3];
    longint raw[3][3], m[3][3];
    int cnt;
    w = b.qw; x = b.qx; y = b.qy; z = b.qz;
    c[0] = b.cx; c[1] = b.cy; c[2] = b.cz;
    h[0] = b.hx; h[1] = b.hy; h[2] = b.hz;
    one = longint'(1) <<< 28;
    raw[0][0] = one - 2 * (y * y + z * z);
    raw[0][1] = 2 * (x * y - w * z);
    raw[0][2] = 2 * (x * z + w * y);
    raw[1][0] = 2 * (x * y + w * z);
    raw[1][1] = one - 2 * (x * x + z * z);
    raw[1][2] = 2 * (y * z - w * x);
    raw[2][0] = 2 * (x * z - w * y);
    raw[2][1] = 2 * (y * z + w * x);
    raw[2][2] = one - 2 * (x * x + y * y);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = rnd_shift(raw[i][j], 12);
    maxpen = 0; sumx = 0; sumz = 0; cnt = 0;
    for (int k = 0; k < 8; k++) begin
      for (int a = 0; a < 3; a++) loc[a] = ((k >> (2 - a)) & 1) ? h[a] : -h[a];
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int a = 0; a < 3; a++) acc += m[i][a] * loc[a];
        wc[i] = c[i] + rnd_shift(acc, 16);
      end
      if (wc[1] < longint'(gnd)) begin
        pen = longint'(gnd) - wc[1];
        if (pen > maxpen) maxpen = pen;
        sumx += wc[0];
        sumz += wc[2];
        cnt++;
      end
    end
    r = '0;
    if (cnt != 0) begin
      if (maxpen > 64'sh7FFFFFFF) maxpen = 64'sh7FFFFFFF;
      r.hit = 1'b1;
      r.pen = maxpen[30:0];
      r.cx  = sat32(fdiv(2 * sumx + cnt, 2 * longint'(cnt)));
      r.cz  = sat32(fdiv(2 * sumz + cnt, 2 * longint'(cnt)));
    end
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_box(box_t b);
    return {3'b000, b.hz, b.hy, b.hx, b.qz, b.qy, b.qx, b.qw, b.cz, b.cy, b.cx};
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic send_box(box_t b, logic typed, contact_t r);
    while ($urandom_range(99, 0) < idle_s) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_box(b);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_contacts.insert(pending_contacts.size(), typed ? r : contact_of(b, ground_q));
    n_boxes++;
  endtask

  task automatic drain_and_write(logic signed [31:0] g);
    s_axis_tvalid <= 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ground_q = g;
  endtask

  function automatic logic signed [31:0] near(logic signed [31:0] g, int span);
    longint v;
    v = longint'(g) + $signed($urandom_range(2 * span, 0)) - span;
    return sat32(v);
  endfunction

  function automatic box_t random_box();
    box_t b;
    int   pick;
    b = box_t'(($bits(box_t))'({$urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom}));
    pick = $urandom_range(3, 0);
    if (pick == 1 || pick == 2) begin
      b.cy = near(ground_q, 1 << 21);
      b.hx = 31'($urandom_range(1 << 20, 0));
      b.hy = 31'($urandom_range(1 << 20, 0));
      b.hz = 31'($urandom_range(1 << 20, 0));
      b.qw = 16'($signed($urandom_range(32768, 0)) - 16384);
      b.qx = 16'($signed($urandom_range(32768, 0)) - 16384);
      b.qy = 16'($signed($urandom_range(32768, 0)) - 16384);
      b.qz = 16'($signed($urandom_range(32768, 0)) - 16384);
    end
    if (pick == 2) begin
      b.qw = 0; b.qx = 0; b.qy = 0; b.qz = 0;
      case ($urandom_range(3, 0))
        0: b.qw = $urandom_range(1, 0) ? 16'sd16384 : -16'sd16384;
        1: b.qx = $urandom_range(1, 0) ? 16'sd16384 : -16'sd16384;
        2: b.qy = $urandom_range(1, 0) ? 16'sd16384 : -16'sd16384;
        default: b.qz = $urandom_range(1, 0) ? 16'sd16384 : -16'sd16384;
      endcase
    end
    if (pick == 3) b.cy = near(ground_q, 1 << 30);
    return b;
  endfunction

  always @(posedge clk_i) begin
    contact_t got, want;
    m_axis_tready <= ($urandom_range(99, 0) >= idle_r);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[63:32], m_axis_tdata[95:64]} == 0 ? '0 : '0;
      got.hit = m_axis_tdata[0];
      got.pen = m_axis_tdata[31:1];
      got.cx  = m_axis_tdata[63:32];
      got.cz  = m_axis_tdata[95:64];
      n_contacts++;
      if (got.hit) n_hits++;
      if (pending_contacts.size() == 0) begin
        report_mismatch("unexpected result, hit", got.hit, 0);
      end else begin
        want = pending_contacts.pop_front();
        if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
        if (got.pen != want.pen) report_mismatch("penetration", got.pen, want.pen);
        if (got.cx != want.cx) report_mismatch("contact_x", got.cx, want.cx);
        if (got.cz != want.cz) report_mismatch("contact_z", got.cz, want.cz);
      end
    end
    if (quiet >= WDOG) begin
      $display("watchdog: no transaction for %0d cycles", WDOG);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] grounds[4];
    int chunk;
    dir_tab[0]  = '{'{0, 0, 0, 16384, 0, 0, 0, 65536, 65536, 65536},
                    1'b1, '{1'b1, 31'd65536, 0, 0}};
    dir_tab[1]  = '{'{0, 131072, 0, 16384, 0, 0, 0, 65536, 65536, 65536},
                    1'b1, '{1'b0, 31'd0, 0, 0}};
    dir_tab[2]  = '{'{0, 65536, 0, 16384, 0, 0, 0, 65536, 65536, 65536},
                    1'b1, '{1'b0, 31'd0, 0, 0}};
    dir_tab[3]  = '{'{0, 32'sh80000000, 0, 16384, 0, 0, 0,
                      31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF},
                    1'b1, '{1'b1, 31'h7FFFFFFF, 0, 0}};
    dir_tab[4]  = '{'{12345, -4000, 777, -32768, -32768, -32768, -32768,
                      65536, 65536, 65536}, 1'b0, '0};
    dir_tab[5]  = '{'{-99, -70000, 5, 0, 0, 0, 0, 65536, 131072, 65536}, 1'b0, '0};
    dir_tab[6]  = '{'{0, 30000, 0, 11585, 0, 0, 11585, 65536, 20000, 65536}, 1'b0, '0};
    dir_tab[7]  = '{'{32'sh7FFFFFFF, 0, 32'sh80000000, 13377, 6270, 6270, 0,
                      31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF}, 1'b0, '0};
    dir_tab[8]  = '{'{0, 0, 0, 16384, 0, 0, 0, 0, 0, 0}, 1'b1, '{1'b0, 31'd0, 0, 0}};
    dir_tab[9]  = '{'{5, -1, -7, 16384, 0, 0, 0, 0, 0, 0}, 1'b1, '{1'b1, 31'd1, 5, -7}};
    dir_tab[10] = '{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16384, 16384, 16384,
                      16384, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF}, 1'b0, '0};
    dir_tab[11] = '{'{-1, -1, -1, 32767, 32767, 32767, 32767, 1, 2, 3}, 1'b0, '0};
    grounds[0] = $signed($urandom_range(1 << 24, 0)) - (1 << 23);
    grounds[1] = 32'sh7FFFFFFF;
    grounds[2] = 32'sh80000000;
    grounds[3] = $urandom;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NDIR; i++) send_box(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].r);
    for (chunk = 0; chunk < 4; chunk++) begin
      drain_and_write(grounds[chunk]);
      idle_s = (chunk == 0) ? 20 : (chunk == 1) ? 68 : 0;
      idle_r = (chunk == 0) ? 68 : (chunk == 1) ? 20 : 0;
      for (int i = 0; i < NRND / 4; i++) send_box(random_box(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    $display("covered %0d boxes, %0d results (%0d hits) over five ground heights",
             n_boxes, n_contacts, n_hits);
    $display("idle patterns: sender heavy, receiver heavy, none; %0d mismatches", mismatches);
    if (mismatches == 0 && n_contacts == n_boxes) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
